[hdl/lslf_pkg.sv]
// ----------------------------------------------------------------------------
// lslf_pkg
// Shared widths, codes and control structs for the least-squares line fit.
// ----------------------------------------------------------------------------
package lslf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_POINTS  = 1024;

    localparam int CNT_LOG = $clog2(MAX_POINTS);
    localparam int COUNT_W = CNT_LOG + 1;
    localparam int SUM_W   = SAMPLE_BITS + CNT_LOG + 1;     // sum of x, sum of y
    localparam int PROD_W  = 2 * SAMPLE_BITS;
    localparam int XY_W    = PROD_W + CNT_LOG;              // sum of x*y, signed
    localparam int XX_W    = PROD_W - 1 + CNT_LOG;          // sum of x*x, unsigned

    // MAC accumulator holds the widest cross term plus guard bit
    localparam int ACC_W     = XY_W + SUM_W + 1;
    localparam int MUL_STEPS = SUM_W;                       // one multiplier bit a cycle
    localparam int DIVN_W    = ACC_W + FRAC_BITS;           // dividend magnitude
    localparam int DIV_STEPS = DIVN_W;                      // one quotient bit a cycle
    localparam int DVSR_W    = 64;                          // divisor / remainder width
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int OUT_W       = 48;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * OUT_W + COUNT_W + STATUS_W + 7) / 8) * 8;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_DEGEN   = 2'd1;
    localparam status_t STATUS_SAT     = 2'd2;
    localparam status_t STATUS_DROPPED = 2'd3;

    // Product terms, in evaluation order. Odd codes are subtracted.
    typedef logic [2:0] mac_sel_t;
    localparam mac_sel_t SEL_N_SXX  = 3'd0;
    localparam mac_sel_t SEL_SX_SX  = 3'd1;
    localparam mac_sel_t SEL_N_SXY  = 3'd2;
    localparam mac_sel_t SEL_SX_SY  = 3'd3;
    localparam mac_sel_t SEL_SY_SXX = 3'd4;
    localparam mac_sel_t SEL_SX_SXY = 3'd5;

    typedef struct packed {
        logic     accum;
        logic     mac_load;
        logic     clear_acc;
        logic     mac_step;
        logic     mac_msb;
        logic     mac_sub;
        mac_sel_t sel;
        logic     latch_d;
        logic     load_sy;
        logic     div_load;
        logic     div_step;
        logic     store_slope;
        logic     store_icpt;
        logic     load_out;
        logic     clear_sums;
    } lslf_cmd_t;

    typedef struct packed {
        logic degen;
    } lslf_stat_t;

endpackage

[hdl/lslf_datapath.sv]
// ----------------------------------------------------------------------------
// lslf_datapath
// Running sums, bit-serial multiply-accumulate, restoring divider, result reg.
// ----------------------------------------------------------------------------
module lslf_datapath (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  lslf_pkg::lslf_cmd_t                      cmd,
    output lslf_pkg::lslf_stat_t                     stat,
    input  logic signed [lslf_pkg::SAMPLE_BITS-1:0]  x_value,
    input  logic signed [lslf_pkg::SAMPLE_BITS-1:0]  y_value,
    output logic        [lslf_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import lslf_pkg::*;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // running sums
    logic        [COUNT_W-1:0] count_reg;
    logic signed [SUM_W-1:0]   sum_x_reg;
    logic signed [SUM_W-1:0]   sum_y_reg;
    logic signed [XY_W-1:0]    sum_xy_reg;
    logic        [XX_W-1:0]    sum_xx_reg;
    logic                      dropped_reg;
    logic signed [PROD_W-1:0]  prod_xy;
    logic signed [PROD_W-1:0]  prod_xx;

    // multiply-accumulate
    logic signed [ACC_W-1:0] op_a;
    logic        [SUM_W-1:0] op_b;
    logic signed [ACC_W-1:0] mul_a_reg;
    logic        [SUM_W-1:0] mul_b_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] term;
    logic        [ACC_W-1:0] acc_mag;
    logic                    degen_now;

    // divider
    logic [DVSR_W-1:0] d_reg;
    logic              degen_reg;
    logic [DIVN_W-1:0] num_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [DIVN_W-1:0] quo_reg;
    logic              neg_reg;
    logic [DVSR_W:0]   rem_sh;
    logic [DVSR_W:0]   rem_diff;
    logic              rem_ge;
    logic              q_sat;
    logic [OUT_W-1:0]  q_mag;
    logic [OUT_W-1:0]  q_res;

    // results
    logic [OUT_W-1:0]       slope_reg;
    logic [OUT_W-1:0]       icpt_reg;
    logic                   sat_reg;
    status_t                status;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    assign prod_xy = PROD_W'(x_value) * PROD_W'(y_value);
    assign prod_xx = PROD_W'(x_value) * PROD_W'(x_value);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_sums) begin
            count_reg   <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            sum_xy_reg  <= '0;
            sum_xx_reg  <= '0;
            dropped_reg <= 1'b0;
        end else if (cmd.accum) begin
            if (count_reg < COUNT_W'(MAX_POINTS)) begin
                count_reg  <= count_reg + 1'b1;
                sum_x_reg  <= sum_x_reg + SUM_W'(x_value);
                sum_y_reg  <= sum_y_reg + SUM_W'(y_value);
                sum_xy_reg <= sum_xy_reg + XY_W'(prod_xy);
                sum_xx_reg <= sum_xx_reg + XX_W'(prod_xx[PROD_W-2:0]);
            end else begin
                dropped_reg <= 1'b1;
            end
        end
    end

    // operand pair for the current product term; narrow operand goes serial
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.sel)
            SEL_N_SXX: begin
                op_a = ACC_W'(sum_xx_reg);
                op_b = SUM_W'(count_reg);
            end
            SEL_SX_SX: begin
                op_a = ACC_W'(sum_x_reg);
                op_b = sum_x_reg;
            end
            SEL_N_SXY: begin
                op_a = ACC_W'(sum_xy_reg);
                op_b = SUM_W'(count_reg);
            end
            SEL_SX_SY: begin
                op_a = ACC_W'(sum_x_reg);
                op_b = sum_y_reg;
            end
            SEL_SY_SXX: begin
                op_a = ACC_W'(sum_xx_reg);
                op_b = sum_y_reg;
            end
            SEL_SX_SXY: begin
                op_a = ACC_W'(sum_xy_reg);
                op_b = sum_x_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // sign bit of the serial operand carries negative weight
    assign term = (cmd.mac_msb ^ cmd.mac_sub) ? -mul_a_reg : mul_a_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mac_load) begin
            mul_a_reg <= op_a;
            mul_b_reg <= op_b;
        end else if (cmd.mac_step) begin
            mul_a_reg <= mul_a_reg <<< 1;
            mul_b_reg <= mul_b_reg >> 1;
        end
        if (cmd.load_sy) begin
            acc_reg <= ACC_W'(sum_y_reg);
        end else if (cmd.mac_load && cmd.clear_acc) begin
            acc_reg <= '0;
        end else if (cmd.mac_step && mul_b_reg[0]) begin
            acc_reg <= acc_reg + term;
        end
    end

    // denominator unusable if not positive or not below 2^(DVSR_W-1)
    assign degen_now  = (|acc_reg[ACC_W-1:DVSR_W-1]) || (acc_reg == '0);
    assign stat.degen = degen_now;

    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign rem_sh   = {rem_reg, num_reg[DIVN_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvsr_reg};
    assign rem_ge   = rem_sh >= {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            neg_reg  <= acc_reg[ACC_W-1];
            num_reg  <= DIVN_W'(acc_mag) << FRAC_BITS;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvsr_reg <= degen_reg ? DVSR_W'(count_reg) : d_reg;
        end else if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            rem_reg <= rem_ge ? rem_diff[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
            quo_reg <= {quo_reg[DIVN_W-2:0], rem_ge};
        end
    end

    // saturate the quotient magnitude; the most negative value is exact
    assign q_sat = (|quo_reg[DIVN_W-1:OUT_W-1]) &&
                   !(neg_reg && (quo_reg == (DIVN_W'(1) << (OUT_W-1))));
    assign q_mag = q_sat ? (neg_reg ? OUT_MIN : OUT_MAX) : quo_reg[OUT_W-1:0];
    assign q_res = neg_reg ? OUT_W'(-q_mag) : q_mag;

    always_ff @(posedge aclk) begin
        if (cmd.latch_d) begin
            d_reg     <= acc_reg[DVSR_W-1:0];
            degen_reg <= degen_now;
            slope_reg <= '0;
            sat_reg   <= 1'b0;
        end else if (cmd.store_slope) begin
            slope_reg <= q_res;
            sat_reg   <= sat_reg | q_sat;
        end else if (cmd.store_icpt) begin
            icpt_reg <= q_res;
            if (!degen_reg) begin
                sat_reg <= sat_reg | q_sat;
            end
        end
    end

    always_comb begin
        if (dropped_reg) begin
            status = STATUS_DROPPED;
        end else if (degen_reg) begin
            status = STATUS_DEGEN;
        end else if (sat_reg) begin
            status = STATUS_SAT;
        end else begin
            status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= OUT_TDATA_W'({status, count_reg, icpt_reg, slope_reg});
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

[hdl/lslf_ctrl.sv]
// ----------------------------------------------------------------------------
// lslf_ctrl
// Sequencer: accumulate, then the product terms, divisions and result hand-off.
// ----------------------------------------------------------------------------
module lslf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  lslf_pkg::lslf_stat_t  stat,
    output lslf_pkg::lslf_cmd_t   cmd
);
    import lslf_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOAD    = 3'd1;
    localparam logic [2:0] ST_MAC     = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_DIVLOAD = 3'd4;
    localparam logic [2:0] ST_DIV     = 3'd5;
    localparam logic [2:0] ST_STORE   = 3'd6;
    localparam logic [2:0] ST_OUT     = 3'd7;

    logic [2:0]        state_reg, state_next;
    mac_sel_t          phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              sub_term;
    logic              mul_last;
    logic              div_last;

    always_comb begin
        case (phase_reg) inside
            SEL_SX_SX, SEL_SX_SY, SEL_SX_SXY: sub_term = 1'b1;
            default:                          sub_term = 1'b0;
        endcase
    end

    assign mul_last = (step_reg == STEP_W'(MUL_STEPS - 1));
    assign div_last = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        cmd.sel       = phase_reg;
        cmd.mac_sub   = sub_term;
        cmd.clear_acc = !sub_term;
        cmd.mac_msb   = mul_last;
        state_next    = state_reg;
        phase_next    = phase_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accum = 1'b1;
                    if (s_tlast) begin
                        phase_next = SEL_N_SXX;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                cmd.mac_load = 1'b1;
                step_next    = '0;
                state_next   = ST_MAC;
            end
            ST_MAC: begin
                cmd.mac_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (mul_last) begin
                    case (phase_reg) inside
                        SEL_SX_SX: begin
                            state_next = ST_CHECK;
                        end
                        SEL_SX_SY, SEL_SX_SXY: begin
                            state_next = ST_DIVLOAD;
                        end
                        default: begin
                            phase_next = phase_reg + 1'b1;
                            state_next = ST_LOAD;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                cmd.latch_d = 1'b1;
                if (stat.degen) begin
                    // mean of y instead of a fit
                    cmd.load_sy = 1'b1;
                    state_next  = ST_DIVLOAD;
                end else begin
                    phase_next = SEL_N_SXY;
                    state_next = ST_LOAD;
                end
            end
            ST_DIVLOAD: begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (div_last) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (phase_reg == SEL_SX_SY) begin
                    cmd.store_slope = 1'b1;
                    phase_next      = SEL_SY_SXX;
                    state_next      = ST_LOAD;
                end else begin
                    cmd.store_icpt = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out   = 1'b1;
                    cmd.clear_sums = 1'b1;
                    m_tvalid_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= SEL_N_SXX;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[hdl/least_squares_line_fit_core.sv]
// ----------------------------------------------------------------------------
// least_squares_line_fit_core
// Straight-line least-squares fit over a stream of signed (x, y) points.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one (x, y) point per item; s_tlast marks the final point of a
//   data set. Points are summed at one item per cycle while the core is idle.
//   After the last point the fit runs: up to six product terms on a bit-serial
//   multiply-accumulate and up to two restoring divisions. A degenerate set
//   runs fewer of both, and the mean of y is returned instead of a fit.
//   s_tready stays low during the fit.
//   m_ channel: one result item per data set: slope and intercept in Q.16,
//   point count and status. The result waits in an output register; new
//   points are taken while it waits, but the next fit holds at its end until
//   the previous result is taken.
//   Points past capacity are ignored and flagged in status.
//   Reset (aresetn low, synchronous) clears the sums and any pending result.
// ----------------------------------------------------------------------------
module least_squares_line_fit_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [lslf_pkg::IN_TDATA_W-1:0]        s_tdata,   // x_value, y_value
    input  logic                                   s_tlast,   // last point of set
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [lslf_pkg::OUT_TDATA_W-1:0]       m_tdata    // slope, intercept,
                                                              // point_count, status
);
    import lslf_pkg::*;

    lslf_cmd_t                      cmd;
    lslf_stat_t                     stat;
    logic signed [SAMPLE_BITS-1:0]  x_value;
    logic signed [SAMPLE_BITS-1:0]  y_value;

    // x in the low half of tdata, y above it
    assign x_value = s_tdata[SAMPLE_BITS-1:0];
    assign y_value = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    lslf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lslf_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .x_value (x_value),
        .y_value (y_value),
        .m_tdata (m_tdata)
    );

endmodule

[hdl/lslf_checker.sv]
// ----------------------------------------------------------------------------
// lslf_checker
// Port-level checks on the line fit core, bound to the top level.
// ----------------------------------------------------------------------------
module lslf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lslf_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import lslf_pkg::*;

    localparam int CNT_LSB = 2 * OUT_W;
    localparam int STS_LSB = CNT_LSB + COUNT_W;

    logic [OUT_W-1:0]   slope_f;
    logic [COUNT_W-1:0] count_f;
    status_t            status_f;

    assign slope_f  = m_tdata[OUT_W-1:0];
    assign count_f  = m_tdata[STS_LSB-1:CNT_LSB];
    assign status_f = m_tdata[STS_LSB+STATUS_W-1:STS_LSB];

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the last point starts the fit and closes the input
    a_fit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input open right after last point");

    // a degenerate set has zero slope
    a_degen_slope: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status_f == STATUS_DEGEN) |-> slope_f == '0)
        else $error("degenerate fit with nonzero slope");

    // a result always covers at least one and at most capacity points
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (count_f != '0) && (count_f <= COUNT_W'(MAX_POINTS)))
        else $error("point count out of range");

    // a new result only appears at the end of a fit
    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared outside a fit");

endmodule

bind least_squares_line_fit_core lslf_checker u_lslf_checker (.*);
